/* rtl/core/i2p_pkg.sv */
// ============================================================================
// i2p_pkg
// Shared types, codes and the operator precedence table of the infix to
// postfix converter.
// ============================================================================
package i2p_pkg;

   // Default operator stack depth.
   localparam int STACK_DEPTH_DEF = 32;

   // Token action codes on the request channel.
   localparam logic [1:0] ACT_IDENT    = 2'd0;
   localparam logic [1:0] ACT_NUMBER   = 2'd1;
   localparam logic [1:0] ACT_OPERATOR = 2'd2;
   localparam logic [1:0] ACT_END      = 2'd3;

   // Result kind codes on the response channel.
   localparam logic [1:0] KIND_OPERATOR = 2'd2;

   // Operator characters.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ASSIGN = 8'h3D;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;        // latch the incoming token
      logic load_operand;  // place the incoming operand in the pending slot
      logic pop;           // drop the top of the stack
      logic emit_top;      // place the top of the stack in the pending slot
      logic emit_ovf;      // place the dropped operator in the pending slot
      logic push;          // push the latched operator
      logic finish;        // release the pending result marked as last
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_is_operand;
      logic in_is_lparen;
      logic in_is_rparen;
      logic tok_is_end;
      logic tok_is_rparen;
      logic count_zero;
      logic full;
      logic top_is_lparen;
      logic top_is_paren;
      logic top_ge;        // top precedence is at least the token's
      logic room;          // a new result can enter the pending slot
   } sts_type;

   // Precedence shifted up by one so that unknown characters rank zero.
   function automatic logic [3:0] prec_rank(input logic [7:0] c);
      logic [3:0] r;
      unique case (c)
         CH_PLUS, CH_MINUS:         r = 4'd6;
         CH_STAR, CH_SLASH, CH_PCT: r = 4'd7;
         CH_CARET:                  r = 4'd8;
         CH_RPAREN:                 r = 4'd5;
         CH_LPAREN:                 r = 4'd9;
         CH_ASSIGN:                 r = 4'd4;
         default:                   r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/i2p_ram.sv */
// ============================================================================
// i2p_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/i2p_datapath.sv */
// ============================================================================
// i2p_datapath
// Token latch, operator stack, pending result slot and output register.
// ============================================================================
module i2p_datapath #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  i2p_pkg::cmd_type cmd,
   output i2p_pkg::sts_type sts,
   input  logic [1:0]       req_action,
   input  logic [31:0]      req_operand_value,
   input  logic [7:0]       req_operator_char,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [31:0]      rsp_out_value,
   output logic [7:0]       rsp_out_operator,
   output logic             rsp_last,
   output logic             rsp_overflow
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [1:0]       tok_action_ff;
   logic [7:0]       tok_char_ff;
   logic [CNT_W-1:0] count_ff, count_in, count_dec;
   logic [7:0]       top;

   logic             pend_valid_ff, pend_valid_in;
   logic [1:0]       pend_kind_ff, pend_kind_in;
   logic [31:0]      pend_value_ff, pend_value_in;
   logic [7:0]       pend_op_ff, pend_op_in;
   logic             pend_ovf_ff, pend_ovf_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff;
   logic [31:0]      out_value_ff;
   logic [7:0]       out_op_ff;
   logic             out_last_ff;
   logic             out_ovf_ff;

   logic             emit_any, move_out;

   assign count_dec = count_ff - CNT_W'(1);

   // The read address always follows the current top, so the top is valid
   // in the cycle after the count settles.
   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (tok_char_ff),
      .rd_addr (count_dec[ADDR_W-1:0]),
      .rd_data (top)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_dec;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign emit_any = cmd.load_operand | cmd.emit_top | cmd.emit_ovf;
   assign move_out = (emit_any | cmd.finish) & pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_value_in = pend_value_ff;
      pend_op_in    = pend_op_ff;
      pend_ovf_in   = pend_ovf_ff;
      priority if (cmd.load_operand) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = req_action;
         pend_value_in = req_operand_value;
         pend_op_in    = '0;
         pend_ovf_in   = 1'b0;
      end else if (cmd.emit_top) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = i2p_pkg::KIND_OPERATOR;
         pend_value_in = '0;
         pend_op_in    = top;
         pend_ovf_in   = 1'b0;
      end else if (cmd.emit_ovf) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = i2p_pkg::KIND_OPERATOR;
         pend_value_in = '0;
         pend_op_in    = tok_char_ff;
         pend_ovf_in   = 1'b1;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (move_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tok_action_ff <= req_action;
         tok_char_ff   <= req_operator_char;
      end
      pend_kind_ff  <= pend_kind_in;
      pend_value_ff <= pend_value_in;
      pend_op_ff    <= pend_op_in;
      pend_ovf_ff   <= pend_ovf_in;
      if (move_out) begin
         out_kind_ff  <= pend_kind_ff;
         out_value_ff <= pend_value_ff;
         out_op_ff    <= pend_op_ff;
         out_ovf_ff   <= pend_ovf_ff;
         out_last_ff  <= cmd.finish;
      end
   end

   always_comb begin
      sts.in_is_operand = (req_action == i2p_pkg::ACT_IDENT) ||
                          (req_action == i2p_pkg::ACT_NUMBER);
      sts.in_is_lparen  = (req_action == i2p_pkg::ACT_OPERATOR) &&
                          (req_operator_char == i2p_pkg::CH_LPAREN);
      sts.in_is_rparen  = (req_action == i2p_pkg::ACT_OPERATOR) &&
                          (req_operator_char == i2p_pkg::CH_RPAREN);
      sts.tok_is_end    = (tok_action_ff == i2p_pkg::ACT_END);
      sts.tok_is_rparen = (tok_char_ff == i2p_pkg::CH_RPAREN);
      sts.count_zero    = (count_ff == '0);
      sts.full          = (count_ff == CNT_W'(STACK_DEPTH));
      sts.top_is_lparen = (top == i2p_pkg::CH_LPAREN);
      sts.top_is_paren  = (top == i2p_pkg::CH_LPAREN) || (top == i2p_pkg::CH_RPAREN);
      sts.top_ge        = i2p_pkg::prec_rank(top) >= i2p_pkg::prec_rank(tok_char_ff);
      sts.room          = !pend_valid_ff || !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_operator = out_op_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

/* rtl/core/i2p_ctrl.sv */
// ============================================================================
// i2p_ctrl
// Sequencer that steps each token through the stack pops, the push and the
// release of its last result.
// ============================================================================
module i2p_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2p_pkg::sts_type sts,
   output i2p_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CHECK  = 5'b00010,
      S_WAIT   = 5'b00100,
      S_PUSH   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (sts.in_is_operand) begin
                  cmd.load_operand = 1'b1;
                  state_in         = S_FINISH;
               end else if (sts.in_is_rparen && sts.count_zero) begin
                  state_in = S_IDLE;
               end else if (sts.in_is_lparen) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            priority if (sts.tok_is_end) begin
               priority if (sts.count_zero) begin
                  state_in = S_FINISH;
               end else if (sts.top_is_paren) begin
                  cmd.pop  = 1'b1;
                  state_in = S_WAIT;
               end else if (sts.room) begin
                  cmd.pop      = 1'b1;
                  cmd.emit_top = 1'b1;
                  state_in     = S_WAIT;
               end else begin
                  state_in = S_CHECK;
               end
            end else if (sts.tok_is_rparen) begin
               priority if (sts.count_zero) begin
                  state_in = S_FINISH;
               end else if (sts.top_is_lparen) begin
                  cmd.pop  = 1'b1;
                  state_in = S_FINISH;
               end else if (sts.room) begin
                  cmd.pop      = 1'b1;
                  cmd.emit_top = 1'b1;
                  state_in     = S_WAIT;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               priority if (sts.count_zero || sts.top_is_lparen || !sts.top_ge) begin
                  state_in = S_PUSH;
               end else if (sts.room) begin
                  cmd.pop      = 1'b1;
                  cmd.emit_top = 1'b1;
                  state_in     = S_WAIT;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_WAIT: begin
            state_in = S_CHECK;
         end
         S_PUSH: begin
            if (sts.full) begin
               if (sts.room) begin
                  cmd.emit_ovf = 1'b1;
                  state_in     = S_FINISH;
               end
            end else begin
               cmd.push = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.room) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// ============================================================================
// infix_to_postfix_converter_unit
// Shunting-yard converter that turns a stream of infix tokens into postfix.
// ============================================================================
// One token item enters on the req_ channel when req_valid is high and
// req_stall is low. Operands pass straight through; operators go through an
// operator stack held in a RAM; an end-of-expression token flushes the stack
// without its parentheses. Results leave on the rsp_ channel, one item per
// accepted handshake, and rsp_last marks the final result caused by a token.
// A push onto a full stack is dropped and reported as one operator result
// with rsp_overflow set.
// Sequence: the block takes one token at a time. An operand passes idle and
// finish; an open parenthesis idle, push and finish; a close parenthesis on
// an empty stack idle alone. Other tokens pass check and a pop per entry
// they remove, with a wait before each new check, then push unless they are
// a close parenthesis or end token, and finish. The wait lets the registered
// RAM read show the new top. A result is held in a pending slot until it is
// known whether it is the last one, so it reaches rsp_ only when the next
// result or the finish moves it on to the output register. After a token's
// last result has been moved to the output register, the next token is
// accepted even while that result waits on a stalled receiver. While
// rsp_stall is high the block holds its output and pauses as soon as its
// pending slot must move on. Reset, synchronous and active high, empties the
// stack and drops any results in flight; the stack RAM needs no clearing.
// ============================================================================
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_operand_value,
   input  logic [7:0]  req_operator_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_out_value,
   output logic [7:0]  rsp_out_operator,
   output logic        rsp_last,
   output logic        rsp_overflow
);

   // Commands and status between the sequencer and the datapath.
   i2p_pkg::cmd_type cmd;
   i2p_pkg::sts_type sts;

   // The sequencer decides pops and pushes from the datapath status.
   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the stack, the pending result and the output register.
   i2p_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .req_operator_char (req_operator_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_operator  (rsp_out_operator),
      .rsp_last          (rsp_last),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

/* test/postfix_checker.sv */
// ----------------------------------------------------------------------------
// postfix_checker
// Watches both channels of the infix to postfix converter. It keeps its own
// operator stack, works out the postfix results of every accepted token and
// compares each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module postfix_checker #(
   parameter int DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_operand_value,
   input  logic [7:0]  req_operator_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_out_kind,
   input  logic [31:0] rsp_out_value,
   input  logic [7:0]  rsp_out_operator,
   input  logic        rsp_last,
   input  logic        rsp_overflow,
   output int          mismatch_count,
   output int          results_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [7:0]  oper;
      logic        last;
      logic        overflow;
   } postfix_result_type;

   logic [7:0]         op_stack [DEPTH];
   int                 stack_depth;
   postfix_result_type step_results [$];
   postfix_result_type postfix_q [$];

   // Unknown characters rank below everything, so they pop every operator above the nearest open parenthesis.
   function automatic int op_precedence(logic [7:0] ch);
      unique case (ch)
         i2p_pkg::CH_ASSIGN:                 return 3;
         i2p_pkg::CH_RPAREN:                 return 4;
         i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: return 5;
         i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH,
         i2p_pkg::CH_PCT:                    return 6;
         i2p_pkg::CH_CARET:                  return 7;
         i2p_pkg::CH_LPAREN:                 return 8;
         default:                            return -1;
      endcase
   endfunction

   function automatic void stage_result(logic [1:0] kind, logic [31:0] value,
                                        logic [7:0] oper, logic ovf);
      postfix_result_type r;
      r.kind     = kind;
      r.value    = value;
      r.oper     = oper;
      r.last     = 1'b0;
      r.overflow = ovf;
      step_results.push_back(r);
   endfunction

   // A push onto a full stack is dropped and reported as an overflow result.
   function automatic void push_operator(logic [7:0] ch);
      if (stack_depth >= DEPTH) begin
         stage_result(i2p_pkg::KIND_OPERATOR, '0, ch, 1'b1);
      end else begin
         op_stack[stack_depth] = ch;
         stack_depth++;
      end
   endfunction

   function automatic void convert_token(logic [1:0] act, logic [31:0] val,
                                         logic [7:0] ch);
      postfix_result_type r;
      int                 prec;
      logic [7:0]         top_ch;
      unique case (act)
         // Operand result kinds share their codes with the action codes.
         i2p_pkg::ACT_IDENT, i2p_pkg::ACT_NUMBER: stage_result(act, val, 8'h00, 1'b0);
         i2p_pkg::ACT_OPERATOR: begin
            if (stack_depth == 0) begin
               if (ch != i2p_pkg::CH_RPAREN) push_operator(ch);
            end else if (ch == i2p_pkg::CH_LPAREN) begin
               push_operator(ch);
            end else if (ch == i2p_pkg::CH_RPAREN) begin
               while (stack_depth > 0 &&
                      op_stack[stack_depth - 1] != i2p_pkg::CH_LPAREN) begin
                  stack_depth--;
                  stage_result(i2p_pkg::KIND_OPERATOR, '0, op_stack[stack_depth],
                               1'b0);
               end
               if (stack_depth > 0) stack_depth--;
            end else begin
               prec = op_precedence(ch);
               while (stack_depth > 0) begin
                  top_ch = op_stack[stack_depth - 1];
                  if (top_ch == i2p_pkg::CH_LPAREN || op_precedence(top_ch) < prec)
                     break;
                  stack_depth--;
                  stage_result(i2p_pkg::KIND_OPERATOR, '0, top_ch, 1'b0);
               end
               push_operator(ch);
            end
         end
         default: begin
            while (stack_depth > 0) begin
               stack_depth--;
               top_ch = op_stack[stack_depth];
               if (top_ch != i2p_pkg::CH_LPAREN && top_ch != i2p_pkg::CH_RPAREN)
                  stage_result(i2p_pkg::KIND_OPERATOR, '0, top_ch, 1'b0);
            end
         end
      endcase
      foreach (step_results[i]) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         postfix_q.push_back(r);
      end
      step_results.delete();
   endfunction

   function automatic void check_field(string field, logic [31:0] want,
                                       logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Results are compared before the token of the same edge is converted,
   // so a result can never be matched against its own token's expectation.
   always @(posedge clock) begin : monitor
      postfix_result_type want;
      if (reset) begin
         stack_depth    = 0;
         mismatch_count = 0;
         postfix_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (postfix_q.size() == 0) begin
               $error("result with nothing expected: kind %0d value 0x%0h operator 0x%0h",
                      rsp_out_kind, rsp_out_value, rsp_out_operator);
               mismatch_count++;
            end else begin
               want = postfix_q.pop_front();
               check_field("out_kind", 32'(want.kind), 32'(rsp_out_kind));
               check_field("out_value", want.value, rsp_out_value);
               check_field("out_operator", 32'(want.oper), 32'(rsp_out_operator));
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            end
         end
         if (req_valid && !req_stall)
            convert_token(req_action, req_operand_value, req_operator_char);
      end
      results_waiting <= postfix_q.size();
   end

endmodule

/* test/infix_to_postfix_converter_unit_tb.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_tb
// Drives token streams into the converter: a directed opening over every
// operator and corner case, then random expressions, noise and parenthesis
// towers deep enough to overflow the stack. A separate checker predicts and
// compares the postfix output; this module gives the verdict.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = i2p_pkg::STACK_DEPTH_DEF;
   localparam int RANDOM_TOKENS = 210;
   // Long enough that the block fills its pending slot and output register
   // and has to stall the request channel.
   localparam int HOLD_CYCLES   = 300;
   // A full flush pops each entry and waits for the new top after each; this
   // leaves ample margin for a trailing token that produces nothing.
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_operand_value;
   logic [7:0]  req_operator_char;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_out_kind;
   logic [31:0] rsp_out_value;
   logic [7:0]  rsp_out_operator;
   logic        rsp_last;
   logic        rsp_overflow;

   int mismatch_count;
   int results_waiting;
   int tokens_sent;
   int cycle_count;

   // Random idling on each side can be switched off for a quiet stretch.
   bit sender_idles;
   bit receiver_idles;
   // Raised once to make the receiver hold off for a long stretch.
   bit hold_request;

   infix_to_postfix_converter_unit #(
      .STACK_DEPTH (DEPTH)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .req_operator_char (req_operator_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_operator  (rsp_out_operator),
      .rsp_last          (rsp_last),
      .rsp_overflow      (rsp_overflow)
   );

   postfix_checker #(
      .DEPTH (DEPTH)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .req_operator_char (req_operator_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_operator  (rsp_out_operator),
      .rsp_last          (rsp_last),
      .rsp_overflow      (rsp_overflow),
      .mismatch_count    (mismatch_count),
      .results_waiting   (results_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that hangs on a missing result ends here as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("infix_to_postfix_converter_unit verification failed");
      $finish;
   end

   // Receiver. Outside the single long hold-off it stalls about 31 percent of
   // the time while idling is enabled. The hold-off is counted here, in
   // its own process, so the sender keeps offering tokens meanwhile.
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 31);
         end
      end
   end

   // Offers one token and returns at the edge that accepts it. Valid stays
   // high after acceptance so that back-to-back tokens never lower and raise
   // it within the same time step; an idle gap lowers it in its own step.
   task automatic send_token(input logic [1:0] act, input logic [31:0] val,
                             input logic [7:0] ch);
      while (sender_idles && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_operand_value <= val;
      req_operator_char <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens_sent++;
   endtask

   // Identifier or number with a random value.
   task automatic send_operand();
      send_token($urandom_range(1) ? i2p_pkg::ACT_NUMBER : i2p_pkg::ACT_IDENT,
                 $urandom, 8'($urandom));
   endtask

   // The operand field is not used for operators, so it carries random bits.
   task automatic send_operator(input logic [7:0] ch);
      send_token(i2p_pkg::ACT_OPERATOR, $urandom, ch);
   endtask

   // Binary operators, weighted toward the known ones; now and then an
   // arbitrary character, which ranks lowest unless it happens to be known.
   function automatic logic [7:0] pick_binary();
      unique case ($urandom_range(9))
         0:       return i2p_pkg::CH_PLUS;
         1:       return i2p_pkg::CH_MINUS;
         2:       return i2p_pkg::CH_STAR;
         3:       return i2p_pkg::CH_SLASH;
         4:       return i2p_pkg::CH_PCT;
         5:       return i2p_pkg::CH_CARET;
         6:       return i2p_pkg::CH_ASSIGN;
         7:       return i2p_pkg::CH_CARET;
         8:       return 8'($urandom);
         default: return i2p_pkg::CH_PLUS;
      endcase
   endfunction

   // A well-formed expression with random nesting. Most of the time every
   // parenthesis is closed; otherwise the end token flushes open ones.
   task automatic send_expression(input int n_ops);
      int open_parens;
      open_parens = 0;
      send_operand();
      for (int i = 0; i < n_ops; i++) begin
         send_operator(pick_binary());
         while ($urandom_range(3) == 0 && open_parens < 6) begin
            send_operator(i2p_pkg::CH_LPAREN);
            open_parens++;
         end
         send_operand();
         while (open_parens > 0 && $urandom_range(2) == 0) begin
            send_operator(i2p_pkg::CH_RPAREN);
            open_parens--;
         end
      end
      if ($urandom_range(4) != 0) begin
         while (open_parens > 0) begin
            send_operator(i2p_pkg::CH_RPAREN);
            open_parens--;
         end
      end
      send_token(i2p_pkg::ACT_END, $urandom, 8'($urandom));
   endtask

   // A stack of open parentheses, optionally with an operator on each level,
   // then one more operator, a few closing parentheses and the end token.
   // Enough levels fill the stack and provoke dropped pushes.
   task automatic send_paren_tower(input int levels, input bit with_ops);
      for (int i = 0; i < levels; i++) begin
         send_operator(i2p_pkg::CH_LPAREN);
         send_operand();
         if (with_ops) send_operator(pick_binary());
      end
      send_operator(pick_binary());
      send_operand();
      repeat ($urandom_range(3)) send_operator(i2p_pkg::CH_RPAREN);
      send_token(i2p_pkg::ACT_END, $urandom, 8'($urandom));
   endtask

   // Any action with any character, parentheses favored, to break sequences.
   task automatic send_noise();
      logic [7:0] ch;
      ch = $urandom_range(1) ? 8'($urandom) :
           ($urandom_range(1) ? i2p_pkg::CH_LPAREN : i2p_pkg::CH_RPAREN);
      send_token(2'($urandom), $urandom, ch);
   endtask

   initial begin
      int directed_end;
      int pick;
      bit pressure_done;
      bit towers_done;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = i2p_pkg::ACT_IDENT;
      req_operand_value = '0;
      req_operator_char = '0;
      tokens_sent       = 0;
      sender_idles      = 1'b1;
      receiver_idles    = 1'b1;
      hold_request      = 1'b0;
      pressure_done     = 1'b0;
      towers_done       = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. A close parenthesis and an end token on an empty
      // stack must produce nothing at all.
      send_operator(i2p_pkg::CH_RPAREN);
      send_token(i2p_pkg::ACT_END, 32'hFFFF_FFFF, 8'hFF);
      // x = N + (y * 1 ^ z) - N / %, with operators back to back at the end, the
      // value extremes, every operator and a matched pair of parentheses.
      send_token(i2p_pkg::ACT_IDENT, 32'h0000_0000, 8'h00);
      send_operator(i2p_pkg::CH_ASSIGN);
      send_token(i2p_pkg::ACT_NUMBER, 32'hFFFF_FFFF, 8'hFF);
      send_operator(i2p_pkg::CH_PLUS);
      send_operator(i2p_pkg::CH_LPAREN);
      send_token(i2p_pkg::ACT_IDENT, 32'h5A5A_5A5A, 8'h00);
      send_operator(i2p_pkg::CH_STAR);
      send_token(i2p_pkg::ACT_NUMBER, 32'h0000_0001, 8'h00);
      send_operator(i2p_pkg::CH_CARET);
      send_token(i2p_pkg::ACT_IDENT, 32'hA5A5_A5A5, 8'h00);
      send_operator(i2p_pkg::CH_RPAREN);
      send_operator(i2p_pkg::CH_MINUS);
      send_token(i2p_pkg::ACT_NUMBER, 32'h8000_0000, 8'h00);
      send_operator(i2p_pkg::CH_SLASH);
      send_operator(i2p_pkg::CH_PCT);
      // Unknown characters at both ends of the byte range pop everything
      // above them.
      send_operator(8'h00);
      send_operator(8'hFF);
      // Close parenthesis without a matching open one empties the stack.
      send_operator(i2p_pkg::CH_RPAREN);
      // Parentheses only: the flush has nothing to emit.
      send_operator(i2p_pkg::CH_LPAREN);
      send_operator(i2p_pkg::CH_LPAREN);
      send_token(i2p_pkg::ACT_END, 32'h0000_0000, 8'h00);
      directed_end = tokens_sent;

      // Random part: mostly well-formed expressions, with noise, small
      // towers, one long receiver hold-off, a quiet stretch and one pair of
      // overflow towers.
      while (tokens_sent < directed_end + RANDOM_TOKENS) begin
         // Quiet stretch with no idling on either side.
         sender_idles   = !(tokens_sent >= directed_end + 30 &&
                            tokens_sent <  directed_end + 70);
         receiver_idles = sender_idles;
         if (!pressure_done && tokens_sent >= directed_end + 15) begin
            hold_request  = 1'b1;
            pressure_done = 1'b1;
         end
         if (!towers_done && tokens_sent >= directed_end + 75) begin
            // Open parentheses alone overflow on the push of an open one;
            // interleaved operators fill the stack with mixed entries.
            send_paren_tower(DEPTH + 2, 1'b0);
            send_paren_tower(DEPTH / 2, 1'b1);
            towers_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 65)
            send_expression($urandom_range(1, 6));
         else if (pick < 82)
            repeat ($urandom_range(1, 4)) send_noise();
         else
            send_paren_tower($urandom_range(1, 8), 1'(($urandom_range(1))));
      end
      req_valid <= 1'b0;

      // Drain: every expected result must arrive, then a margin in which no
      // stray result may appear.
      do @(posedge clock); while (results_waiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_waiting != 0)
         $error("%0d expected results never arrived", results_waiting);

      if (mismatch_count == 0 && results_waiting == 0)
         $display("infix_to_postfix_converter_unit verification clean");
      else
         $display("infix_to_postfix_converter_unit verification failed");
      $finish;
   end

endmodule
